// File: rtl/bptt_pkg.sv
// Package for the buffer pool tag table: opcodes, status codes, word types
// and the command and state types shared by the front and back parts.
// Has no dependencies; every other file of the block uses it.
package bptt_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_MARK   = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OUT_OF_BOUND = 2'd1;
    localparam logic [1:0] ST_NOT_IN_BUF  = 2'd2;

    // Request word.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] block_number;
    } req_word_t;

    // Response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_index;
        logic        writeback_needed;
        logic [12:0] writeback_block;
    } rsp_word_t;

    // Classified command handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_LOOKUP,
        CMD_MARK,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] block;
    } cmd_t;

    // Back part sequencer states.
    typedef enum logic {
        BK_GATHER,
        BK_COMMIT
    } back_state_t;

endpackage

// File: rtl/bptt_front.sv
// Front part of the buffer pool tag table: accepts request words, checks the
// block number range, classifies the opcode and queues commands for the back.
// Depends on bptt_pkg.
module bptt_front #(
    parameter int DISK_BLOCK_COUNT = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bptt_pkg::req_word_t req,
    output logic                cmd_valid,
    input  logic                cmd_pop,
    output bptt_pkg::cmd_t      cmd
);

    localparam int QUEUE_DEPTH = 2;

    bptt_pkg::cmd_t q_reg [QUEUE_DEPTH];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    logic           req_accept;
    logic           in_bound;
    logic           keep;
    logic           push;
    bptt_pkg::cmd_t push_cmd;

    // Range check and opcode decode; the unused opcode is dropped here.
    always_comb
    begin
        in_bound       = {1'b0, req.block_number} < 17'(DISK_BLOCK_COUNT);
        push_cmd.block = req.block_number;
        push_cmd.kind  = bptt_pkg::CMD_REJECT;
        keep           = 1'b1;
        unique case (req.opcode)
            bptt_pkg::OP_ALLOC:  push_cmd.kind = bptt_pkg::CMD_ALLOC;
            bptt_pkg::OP_LOOKUP: push_cmd.kind = bptt_pkg::CMD_LOOKUP;
            bptt_pkg::OP_MARK:   push_cmd.kind = bptt_pkg::CMD_MARK;
            default:             keep = 1'b0;
        endcase
        if (!in_bound)
        begin
            push_cmd.kind = bptt_pkg::CMD_REJECT;
        end
    end

    assign req_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign req_accept = req_valid && req_ready;
    assign push       = req_accept && keep;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // The fill count never passes the queue depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("command queue count out of range");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> count_reg != 2'd0)
        else $error("command queue popped while empty");

endmodule

// File: rtl/bptt_back.sv
// Back part of the buffer pool tag table: holds the slot table, searches it
// through a registered two-level tree, updates it and registers the response.
// Depends on bptt_pkg.
module bptt_back #(
    parameter int SLOT_COUNT       = 32,
    parameter int DISK_BLOCK_COUNT = 8192,
    parameter int AGE_BITS         = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  bptt_pkg::cmd_t      cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bptt_pkg::rsp_word_t rsp
);

    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int TAG_W      = $clog2(DISK_BLOCK_COUNT);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // Per-group search result.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic                free;
        logic [SLOT_W-1:0]   free_slot;
        logic [AGE_BITS-1:0] best_age;
        logic [SLOT_W-1:0]   best_slot;
        logic                best_dirty;
        logic [TAG_W-1:0]    best_tag;
    } grp_t;

    // Slot table.
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic                  dirty_reg [SLOT_COUNT];
    logic                  dirty_next [SLOT_COUNT];
    logic [TAG_W-1:0]      tag_reg [SLOT_COUNT];
    logic [TAG_W-1:0]      tag_next [SLOT_COUNT];
    logic [AGE_BITS-1:0]   age_reg [SLOT_COUNT];
    logic [AGE_BITS-1:0]   age_next [SLOT_COUNT];
    logic [AGE_BITS-1:0]   aged [SLOT_COUNT];

    // Sequencer, current command and group results.
    bptt_pkg::back_state_t state_reg;
    bptt_pkg::back_state_t state_next;
    bptt_pkg::cmd_t        cur_reg;
    bptt_pkg::cmd_t        cur_next;
    grp_t                  grp_reg [NUM_GROUPS];
    grp_t                  grp_next [NUM_GROUPS];
    logic                  commit;

    // Response register.
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    bptt_pkg::rsp_word_t   rsp_reg;
    bptt_pkg::rsp_word_t   rsp_next;

    // Combined search results.
    logic                  hit_found;
    logic [SLOT_W-1:0]     hit_slot;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic [AGE_BITS-1:0]   best_age;
    logic [SLOT_W-1:0]     best_slot;
    logic                  best_dirty;
    logic [TAG_W-1:0]      best_tag;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [TAG_W-1:0]      cur_tag;
    logic [TAG_W-1:0]      head_tag;
    logic [7:0]            slot_ext;
    logic [15:0]           wb_ext;

    assign cur_tag  = cur_reg.block[TAG_W-1:0];
    assign head_tag = cmd.block[TAG_W-1:0];

    // Ages as they stand after one allocation step.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            aged[i] = (valid_reg[i] && age_reg[i] != AGE_MAX) ?
                      age_reg[i] + 1'b1 : age_reg[i];
        end
    end

    // First search level: each group finds its first hit, first free slot
    // and oldest slot for the command at the queue head.
    always_comb
    begin
        int idx;
        int first;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            first                  = g * GROUP_SIZE;
            grp_next[g].hit        = 1'b0;
            grp_next[g].hit_slot   = '0;
            grp_next[g].free       = 1'b0;
            grp_next[g].free_slot  = '0;
            grp_next[g].best_age   = aged[first];
            grp_next[g].best_slot  = SLOT_W'(first);
            grp_next[g].best_dirty = dirty_reg[first];
            grp_next[g].best_tag   = tag_reg[first];
            // Walk down so that the lowest index is the one left standing.
            for (int j = GROUP_SIZE - 1; j >= 0; j--)
            begin
                idx = first + j;
                if (idx < SLOT_COUNT)
                begin
                    if (valid_reg[idx] && tag_reg[idx] == head_tag)
                    begin
                        grp_next[g].hit      = 1'b1;
                        grp_next[g].hit_slot = SLOT_W'(idx);
                    end
                    if (!valid_reg[idx])
                    begin
                        grp_next[g].free      = 1'b1;
                        grp_next[g].free_slot = SLOT_W'(idx);
                    end
                end
            end
            // Strictly greater keeps the lowest index on equal ages.
            for (int j = 1; j < GROUP_SIZE; j++)
            begin
                idx = first + j;
                if (idx < SLOT_COUNT && aged[idx] > grp_next[g].best_age)
                begin
                    grp_next[g].best_age   = aged[idx];
                    grp_next[g].best_slot  = SLOT_W'(idx);
                    grp_next[g].best_dirty = dirty_reg[idx];
                    grp_next[g].best_tag   = tag_reg[idx];
                end
            end
        end
    end

    // Second search level over the registered group results.
    always_comb
    begin
        hit_found  = 1'b0;
        hit_slot   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_reg[g].hit)
            begin
                hit_found = 1'b1;
                hit_slot  = grp_reg[g].hit_slot;
            end
            if (grp_reg[g].free)
            begin
                free_found = 1'b1;
                free_slot  = grp_reg[g].free_slot;
            end
        end
        best_age   = grp_reg[0].best_age;
        best_slot  = grp_reg[0].best_slot;
        best_dirty = grp_reg[0].best_dirty;
        best_tag   = grp_reg[0].best_tag;
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            if (grp_reg[g].best_age > best_age)
            begin
                best_age   = grp_reg[g].best_age;
                best_slot  = grp_reg[g].best_slot;
                best_dirty = grp_reg[g].best_dirty;
                best_tag   = grp_reg[g].best_tag;
            end
        end
        alloc_slot = free_found ? free_slot : best_slot;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bptt_pkg::BK_GATHER:
            begin
                if (cmd_valid)
                begin
                    state_next = bptt_pkg::BK_COMMIT;
                end
            end
            bptt_pkg::BK_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = bptt_pkg::BK_GATHER;
                end
            end
            default: state_next = bptt_pkg::BK_GATHER;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_pop = 1'b0;
        commit  = 1'b0;
        unique case (state_reg)
            bptt_pkg::BK_GATHER: cmd_pop = cmd_valid;
            bptt_pkg::BK_COMMIT: commit  = !rsp_valid_reg || rsp_ready;
            default:
            begin
                cmd_pop = 1'b0;
                commit  = 1'b0;
            end
        endcase
    end

    // Capture the popped command.
    always_comb
    begin
        cur_next = cmd_pop ? cmd : cur_reg;
    end

    // Table update and response word for the committed command.
    always_comb
    begin
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        slot_ext       = 8'(alloc_slot);
        wb_ext         = 16'(best_tag);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            dirty_next[i] = dirty_reg[i];
            tag_next[i]   = tag_reg[i];
            age_next[i]   = age_reg[i];
        end
        if (commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            unique case (cur_reg.kind) inside
                bptt_pkg::CMD_ALLOC:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        age_next[i] = aged[i];
                    end
                    valid_next[alloc_slot] = 1'b1;
                    dirty_next[alloc_slot] = 1'b0;
                    tag_next[alloc_slot]   = cur_tag;
                    age_next[alloc_slot]   = '0;
                    rsp_next.status        = bptt_pkg::ST_OK;
                    rsp_next.slot_index    = slot_ext[4:0];
                    if (!free_found && best_dirty)
                    begin
                        rsp_next.writeback_needed = 1'b1;
                        rsp_next.writeback_block  = wb_ext[12:0];
                    end
                end
                bptt_pkg::CMD_LOOKUP,
                bptt_pkg::CMD_MARK:
                begin
                    slot_ext = 8'(hit_slot);
                    if (hit_found)
                    begin
                        rsp_next.status     = bptt_pkg::ST_OK;
                        rsp_next.slot_index = slot_ext[4:0];
                        if (cur_reg.kind == bptt_pkg::CMD_MARK)
                        begin
                            dirty_next[hit_slot] = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = bptt_pkg::ST_NOT_IN_BUF;
                    end
                end
                bptt_pkg::CMD_REJECT:
                begin
                    rsp_next.status = bptt_pkg::ST_OUT_OF_BOUND;
                end
                default:
                begin
                    rsp_next.status = bptt_pkg::ST_OUT_OF_BOUND;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bptt_pkg::BK_GATHER;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
        if (cmd_pop)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            dirty_reg[i] <= dirty_next[i];
            tag_reg[i]   <= tag_next[i];
            age_reg[i]   <= age_next[i];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An allocation leaves its slot valid.
    a_alloc_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit && cur_reg.kind == bptt_pkg::CMD_ALLOC |=> valid_reg[$past(alloc_slot)])
        else $error("allocated slot not valid");

    // A write-back is only reported when every slot was in use.
    a_wb_full: assert property (@(posedge clk) disable iff (!rst_n)
        commit && rsp_next.writeback_needed |-> &valid_reg)
        else $error("write-back reported with a free slot");

    // A reported hit names a valid slot holding the requested block.
    a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
        commit && hit_found && (cur_reg.kind == bptt_pkg::CMD_LOOKUP ||
            cur_reg.kind == bptt_pkg::CMD_MARK)
        |-> valid_reg[hit_slot] && tag_reg[hit_slot] == cur_tag)
        else $error("hit on a slot that does not hold the block");

endmodule

// File: rtl/buffer_pool_tag_table.sv
// Top level of the buffer pool tag table: front classifier and queue feeding
// the back part that owns the slot table. Depends on bptt_pkg, bptt_front
// and bptt_back.
//
//   Channel   Direction  Handshake            Word
//   req       in         req_valid/req_ready  bptt_pkg::req_word_t
//   rsp       out        rsp_valid/rsp_ready  bptt_pkg::rsp_word_t
//
// The back part takes one word at a time: its gather state pops the word and
// runs the first level of the slot search into registers; its commit state
// ends the search, updates the table and loads the response register. The
// front queue holds two words, so requests are still taken while a response
// waits on rsp_ready, until the queue is full. Unused opcode words are
// accepted and give no response. Reset clears every valid bit at once.
module buffer_pool_tag_table #(
    parameter int SLOT_COUNT       = 32,
    parameter int DISK_BLOCK_COUNT = 8192,
    parameter int AGE_BITS         = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bptt_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bptt_pkg::rsp_word_t rsp
);

    logic           cmd_valid;
    logic           cmd_pop;
    bptt_pkg::cmd_t cmd;

    // Request intake and classification.
    bptt_front #(
        .DISK_BLOCK_COUNT(DISK_BLOCK_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Slot table and response.
    bptt_back #(
        .SLOT_COUNT      (SLOT_COUNT),
        .DISK_BLOCK_COUNT(DISK_BLOCK_COUNT),
        .AGE_BITS        (AGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: sim/tb_buffer_pool_tag_table.sv
// Testbench for buffer_pool_tag_table: random and directed request words with
// random idling on both channels, checked against a scoreboard that models the
// slot table. Depends on bptt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_buffer_pool_tag_table;

    localparam int SLOTS      = 32;
    localparam int DISK       = 8192;
    localparam int AGE_W      = 6;
    localparam int RAND_WORDS = 1450;
    localparam int CYCLE_CAP  = 200000;
    localparam int WORKSET    = 48;

    // The opcode the block accepts but ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Scoreboard: its own copy of the slot table and the responses still owed.
    class tag_table_scoreboard;
        logic                 slot_valid [SLOTS];
        logic                 slot_dirty [SLOTS];
        logic [12:0]          slot_tag   [SLOTS];
        logic [AGE_W-1:0]     slot_age   [SLOTS];
        bptt_pkg::rsp_word_t  pending_rsp[$];
        int                   failures;

        function void clear_table();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_age[i]   = '0;
            end
            pending_rsp.delete();
            failures = 0;
        endfunction

        function int pending_count();
            return pending_rsp.size();
        endfunction

        // Lowest valid slot caching the block, or -1.
        function int find_block(logic [15:0] blk);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_tag[i] == blk[12:0])
                    return i;
            return -1;
        endfunction

        // Apply one accepted request word to the table and queue its response.
        function void predict_response(bptt_pkg::req_word_t w);
            bptt_pkg::rsp_word_t r;
            int                  victim;
            r = '0;
            if (w.opcode == OP_UNUSED)
                return;
            if (w.block_number >= DISK)
            begin
                r.status = bptt_pkg::ST_OUT_OF_BOUND;
            end
            else if (w.opcode == bptt_pkg::OP_ALLOC)
            begin
                // Age every live slot, saturating.
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && slot_age[i] != '1)
                        slot_age[i] = slot_age[i] + 1'b1;
                victim = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (victim < 0 && !slot_valid[i])
                        victim = i;
                // No free slot: evict the oldest, lowest index on ties.
                if (victim < 0)
                begin
                    victim = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (slot_age[i] > slot_age[victim])
                            victim = i;
                    if (slot_dirty[victim])
                    begin
                        r.writeback_needed = 1'b1;
                        r.writeback_block  = slot_tag[victim];
                    end
                end
                slot_valid[victim] = 1'b1;
                slot_dirty[victim] = 1'b0;
                slot_tag[victim]   = w.block_number[12:0];
                slot_age[victim]   = '0;
                r.status           = bptt_pkg::ST_OK;
                r.slot_index       = victim[4:0];
            end
            else
            begin
                victim = find_block(w.block_number);
                if (victim < 0)
                begin
                    r.status = bptt_pkg::ST_NOT_IN_BUF;
                end
                else
                begin
                    if (w.opcode == bptt_pkg::OP_MARK)
                        slot_dirty[victim] = 1'b1;
                    r.status     = bptt_pkg::ST_OK;
                    r.slot_index = victim[4:0];
                end
            end
            pending_rsp.push_back(r);
        endfunction

        // Compare a response word with the oldest one owed.
        function void check_response(bptt_pkg::rsp_word_t got);
            bptt_pkg::rsp_word_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response word with none expected: %p", got);
                failures++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, actual %0d",
                       want.slot_index, got.slot_index);
                failures++;
            end
            if (got.writeback_needed !== want.writeback_needed)
            begin
                $error("writeback_needed: expected %0d, actual %0d",
                       want.writeback_needed, got.writeback_needed);
                failures++;
            end
            if (got.writeback_block !== want.writeback_block)
            begin
                $error("writeback_block: expected %0d, actual %0d",
                       want.writeback_block, got.writeback_block);
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    bptt_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    bptt_pkg::rsp_word_t rsp;

    tag_table_scoreboard sb;
    bptt_pkg::req_word_t stimulus[$];
    logic [15:0]         workset[WORKSET];
    int                  cycle_count = 0;

    buffer_pool_tag_table #(
        .SLOT_COUNT      (SLOTS),
        .DISK_BLOCK_COUNT(DISK),
        .AGE_BITS        (AGE_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // Clock, 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("tb_buffer_pool_tag_table: errors");
            $finish;
        end
    end

    function automatic bptt_pkg::req_word_t make_word(logic [1:0] op, logic [15:0] blk);
        bptt_pkg::req_word_t w;
        w.opcode       = op;
        w.block_number = blk;
        return w;
    endfunction

    // Fresh set of in-range blocks; more than the slots, so evictions happen.
    function automatic void refresh_workset();
        for (int i = 0; i < WORKSET; i++)
            workset[i] = 16'($urandom_range(0, DISK - 1));
    endfunction

    // Mostly allocate, look up and mark over the working set, with some
    // out-of-range, unknown-block and unused-opcode words mixed in.
    function automatic bptt_pkg::req_word_t random_request();
        int          roll;
        logic [1:0]  op;
        logic [15:0] blk;
        roll = $urandom_range(0, 99);
        blk  = workset[$urandom_range(0, WORKSET - 1)];
        if (roll < 35)
            op = bptt_pkg::OP_ALLOC;
        else if (roll < 65)
            op = bptt_pkg::OP_LOOKUP;
        else
            op = bptt_pkg::OP_MARK;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            blk = 16'($urandom_range(DISK, 65535));
        else if (roll < 10)
            blk = 16'($urandom_range(0, DISK - 1));
        else if (roll < 13)
            op = OP_UNUSED;
        return make_word(op, blk);
    endfunction

    // Directed words first, then the random part.
    task automatic build_stimulus();
        int counted;
        bptt_pkg::req_word_t w;
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'd0));
        stimulus.push_back(make_word(bptt_pkg::OP_MARK, 16'd100));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'd8192));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'hFFFF));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'hFFFF));
        stimulus.push_back(make_word(bptt_pkg::OP_MARK, 16'd8192));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'd0));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'd8191));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'd8191));
        stimulus.push_back(make_word(bptt_pkg::OP_MARK, 16'd8191));
        // A second copy of a cached block; lookups must pick the lower slot.
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'd8191));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'd8191));
        stimulus.push_back(make_word(bptt_pkg::OP_MARK, 16'd0));
        stimulus.push_back(make_word(OP_UNUSED, 16'd8191));
        stimulus.push_back(make_word(OP_UNUSED, 16'hFFFF));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'd0));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'd5));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'h1555));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'h0AAA));
        stimulus.push_back(make_word(bptt_pkg::OP_MARK, 16'h1555));
        stimulus.push_back(make_word(bptt_pkg::OP_LOOKUP, 16'h0AAA));
        stimulus.push_back(make_word(bptt_pkg::OP_ALLOC, 16'h2000));
        counted = 0;
        refresh_workset();
        while (counted < RAND_WORDS)
        begin
            if (counted % 300 == 299)
                refresh_workset();
            w = random_request();
            stimulus.push_back(w);
            if (w.opcode != OP_UNUSED)
                counted++;
        end
    endtask

    // Request side: random gap before each word, with bursts of no gaps.
    task automatic drive_requests();
        int gap;
        bit burst;
        burst = 1'b0;
        foreach (stimulus[i])
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= stimulus[i];
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
            sb.predict_response(stimulus[i]);
        end
        req_valid <= 1'b0;
    endtask

    // Response side: random stall before taking each word, with bursts too.
    task automatic accept_responses();
        int stall;
        bit burst;
        burst = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            sb.check_response(rsp);
        end
    endtask

    // Main sequence: reset, stimulus, drain, verdict.
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_ready <= 1'b0;
        sb = new;
        sb.clear_table();
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            accept_responses();
        join_none
        drive_requests();
        while (sb.pending_count() != 0)
            @(posedge clk);
        // Let any late or extra word show up before the verdict.
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending_count() == 0)
            $display("tb_buffer_pool_tag_table: clean");
        else
            $display("tb_buffer_pool_tag_table: errors");
        $finish;
    end

endmodule

// File: buffer_pool_tag_table.f
rtl/bptt_pkg.sv
rtl/bptt_front.sv
rtl/bptt_back.sv
rtl/buffer_pool_tag_table.sv
sim/tb_buffer_pool_tag_table.sv
